@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fwh_pkg.sv @@
// package for the formula word hash: constants, types and seed table
// no dependencies
package fwh_pkg;

    localparam int MaxOps   = 4;
    localparam int OpBits   = 9;
    localparam int ProgBits = 36;
    localparam int AddrBits = 6;

    localparam logic [AddrBits-1:0] ADDR_INIT_A = 6'd0;
    localparam logic [AddrBits-1:0] ADDR_INIT_B = 6'd8;
    localparam logic [AddrBits-1:0] ADDR_INIT_C = 6'd16;
    localparam logic [AddrBits-1:0] ADDR_SEED   = 6'd24;
    localparam logic [AddrBits-1:0] ADDR_OPCNT  = 6'd32;
    localparam logic [AddrBits-1:0] ADDR_PROG   = 6'd40;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_XOR = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;

    // datapath commands
    typedef struct packed {
        logic       load;      // capture word, reload vars if first
        logic       first;
        logic [1:0] op_idx;
        logic       op_start;  // start one operation
    } fwh_cmd_t;

    typedef struct packed {
        logic op_done;         // operation finished, result written back unless the code is unknown
    } fwh_stat_t;

    function automatic logic [63:0] seed_of(input logic [2:0] sel);
        logic [31:0] s;
        case (sel)
            3'd0: s = 32'hE7F4CB62;
            3'd1: s = 32'hF6A14FFC;
            3'd2: s = 32'hAA5504AF;
            3'd3: s = 32'h871FCDC2;
            3'd4: s = 32'h11BF6A18;
            3'd5: s = 32'hC57292E6;
            3'd6: s = 32'h7927D27E;
            default: s = 32'h2FEC8733;
        endcase
        return {32'd0, s};
    endfunction

endpackage

@@ rtl/fwh_stream_if.sv @@
// valid/ready stream interface with a generic payload
// depends on nothing
interface fwh_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fwh_datapath.sv @@
// datapath: four 64-bit variables, shared alu with multi-cycle mul and div
// depends on fwh_pkg and assert_macros.svh
module fwh_datapath
    import fwh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  fwh_cmd_t            cmd,
    output fwh_stat_t           stat,
    input  logic [31:0]         word,
    input  logic [63:0]         init_a,
    input  logic [63:0]         init_b,
    input  logic [63:0]         init_c,
    input  logic [2:0]          seed_select,
    input  logic [ProgBits-1:0] op_program,
    output logic [31:0]         checksum,
    output logic                bad_op
);
    logic [63:0] var_reg [4];
    logic        bad_reg;
    logic        busy_reg;
    logic [1:0]  dst_reg;
    logic [2:0]  code_reg;
    logic [63:0] x_reg, y_reg;
    logic [6:0]  cnt_reg;      // mul: 4 partial steps; div: 64 steps
    logic [63:0] acc_reg;      // mul accumulator / div quotient
    logic [63:0] rem_reg;
    logic [63:0] xs_reg;       // div shifting dividend

    logic [OpBits-1:0] bits;
    logic [1:0]  dst, s1, s2;
    logic [2:0]  code;
    logic [65:0] trial;
    logic [64:0] rem_sh;
    logic [63:0] pp;

    always_comb
    begin
        bits = op_program[cmd.op_idx*OpBits +: OpBits];
        dst  = bits[1:0];
        s1   = bits[3:2];
        code = bits[6:4];
        s2   = bits[8:7];
        // partial remainder keeps its top bit, divisor may exceed 2^63
        rem_sh = {rem_reg, xs_reg[63]};
        trial  = {1'b0, rem_sh} - {2'b00, y_reg};
        // 16x64 partial product, shifted by the step position
        pp = (y_reg * {48'd0, x_reg[cnt_reg[1:0]*16 +: 16]}) << (cnt_reg[1:0]*16);
    end

    assign checksum = var_reg[2][31:0];
    assign bad_op   = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                var_reg[i] <= '0;
            end
            bad_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            stat.op_done  <= 1'b0;
            cnt_reg       <= '0;
            dst_reg       <= '0;
            code_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            xs_reg        <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            stat.op_done <= 1'b0;
            if (cmd.load)
            begin
                if (cmd.first)
                begin
                    var_reg[0] <= init_a ^ seed_of(seed_select);
                    var_reg[1] <= init_b;
                    var_reg[2] <= init_c;
                    bad_reg    <= 1'b0;
                end
                var_reg[3] <= {32'd0, word};
            end
            else if (cmd.op_start)
            begin
                dst_reg  <= dst;
                code_reg <= code;
                x_reg    <= var_reg[s1];
                y_reg    <= var_reg[s2];
                xs_reg   <= var_reg[s1];
                acc_reg  <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                case (code_reg)
                    OP_ADD:
                    begin
                        var_reg[dst_reg] <= x_reg + y_reg;
                        busy_reg <= 1'b0;
                        stat.op_done <= 1'b1;
                    end
                    OP_SUB:
                    begin
                        var_reg[dst_reg] <= x_reg - y_reg;
                        busy_reg <= 1'b0;
                        stat.op_done <= 1'b1;
                    end
                    OP_XOR:
                    begin
                        var_reg[dst_reg] <= x_reg ^ y_reg;
                        busy_reg <= 1'b0;
                        stat.op_done <= 1'b1;
                    end
                    OP_MUL:
                    begin
                        if (cnt_reg == 7'd4)
                        begin
                            var_reg[dst_reg] <= acc_reg;
                            busy_reg <= 1'b0;
                            stat.op_done <= 1'b1;
                        end
                        else
                        begin
                            acc_reg <= acc_reg + pp;
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                    OP_DIV:
                    begin
                        if (y_reg == 64'd0)
                        begin
                            var_reg[dst_reg] <= '1;
                            busy_reg <= 1'b0;
                            stat.op_done <= 1'b1;
                        end
                        else if (cnt_reg == 7'd64)
                        begin
                            var_reg[dst_reg] <= acc_reg;
                            busy_reg <= 1'b0;
                            stat.op_done <= 1'b1;
                        end
                        else
                        begin
                            // restoring division, one quotient bit a cycle
                            xs_reg <= {xs_reg[62:0], 1'b0};
                            if (!trial[65])
                            begin
                                rem_reg <= trial[63:0];
                                acc_reg <= {acc_reg[62:0], 1'b1};
                            end
                            else
                            begin
                                rem_reg <= rem_sh[63:0];
                                acc_reg <= {acc_reg[62:0], 1'b0};
                            end
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                    default:
                    begin
                        bad_reg  <= 1'b1;
                        busy_reg <= 1'b0;
                        stat.op_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, busy_reg, !cmd.op_start && !cmd.load)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, stat.op_done, !busy_reg)
    `ASSERT_IMPL(a_div_bound, clk, rst_n, busy_reg, cnt_reg <= 7'd64)
endmodule

@@ rtl/fwh_ctrl.sv @@
// controller: sequences load, operations and result beat
// depends on fwh_pkg and assert_macros.svh
module fwh_ctrl
    import fwh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_first,
    input  logic       in_last,
    input  logic [2:0] op_count,
    input  fwh_stat_t  stat,
    output fwh_cmd_t   cmd,
    output logic       emit
);
    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} state_t;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] n_reg, n_next;
    logic       last_reg, last_next;
    logic       accept;

    assign accept = in_valid && in_ready;
    assign emit   = (state_reg == S_EMIT);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        last_next  = last_reg;
        in_ready   = (state_reg == S_IDLE);
        cmd.load     = accept;
        cmd.first    = in_first;
        cmd.op_idx   = k_reg[1:0];
        cmd.op_start = (state_reg == S_START);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next    = (op_count > 3'(MaxOps)) ? 3'(MaxOps) : op_count;
                    last_next = in_last;
                    k_next    = '0;
                    if (n_next != 3'd0)
                        state_next = S_START;
                    else if (in_last)
                        state_next = S_EMIT;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.op_done)
                begin
                    k_next = k_reg + 3'd1;
                    if (k_next != n_reg)
                        state_next = S_START;
                    else if (last_reg)
                        state_next = S_EMIT;
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            last_reg  <= last_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_k_range, clk, rst_n, state_reg == S_START, k_reg < n_reg)
    `ASSERT_NEXT(a_start_wait, clk, rst_n, state_reg == S_START, state_reg == S_WAIT)
endmodule

@@ rtl/formula_word_hash_top.sv @@
// top level of the formula word hash: config port, output register, glue
// depends on fwh_pkg, fwh_stream_if, fwh_ctrl, fwh_datapath, assert_macros.svh
//
// usage:
//  in channel  (sink):   beat = {last, first, data_word[31:0]}
//  out channel (source): beat = {status, checksum[31:0]}, one per last word
//  apb port writes init_a/b/c, seed_select, op_count, op_program at 8*i
//  sequence: the word is loaded, then each operation is issued and run;
//  mul sums four 16-bit partial products, div makes one quotient bit a
//  cycle and skips the bit loop when the divisor is 0
//  a last word then fills the output register
//  one word at a time; a word with op_count zero runs no operations
//  the result beat sits in an output register; while it waits the block
//  keeps hashing following words, and only a second last word stalls
//  reset clears all variables, config registers and the error flag
module formula_word_hash_top
    import fwh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    fwh_stream_if.sink          in_ch,
    fwh_stream_if.source        out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    logic [63:0]         init_a_reg, init_b_reg, init_c_reg;
    logic [2:0]          seed_reg;
    logic [2:0]          opcnt_reg;
    logic [ProgBits-1:0] prog_reg;

    fwh_cmd_t  cmd;
    fwh_stat_t stat;
    logic      emit;
    logic      ctrl_ready;
    logic [31:0] checksum;
    logic        bad_op;
    logic        out_valid_reg;
    logic [32:0] out_data_reg;

    assign pready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_a_reg <= '0;
            init_b_reg <= '0;
            init_c_reg <= '0;
            seed_reg   <= '0;
            opcnt_reg  <= '0;
            prog_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_INIT_A: init_a_reg <= pwdata;
                ADDR_INIT_B: init_b_reg <= pwdata;
                ADDR_INIT_C: init_c_reg <= pwdata;
                ADDR_SEED:   seed_reg   <= pwdata[2:0];
                ADDR_OPCNT:  opcnt_reg  <= pwdata[2:0];
                ADDR_PROG:   prog_reg   <= pwdata[ProgBits-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_INIT_A: prdata = init_a_reg;
            ADDR_INIT_B: prdata = init_b_reg;
            ADDR_INIT_C: prdata = init_c_reg;
            ADDR_SEED:   prdata = {61'd0, seed_reg};
            ADDR_OPCNT:  prdata = {61'd0, opcnt_reg};
            ADDR_PROG:   prdata = {28'd0, prog_reg};
            default:     prdata = '0;
        endcase
    end

    // hold input while the output register is full and this word is last
    logic in_valid_gated;
    assign in_valid_gated = in_ch.valid && !(out_valid_reg && in_ch.data[33]);
    assign in_ch.ready    = ctrl_ready && !(out_valid_reg && in_ch.data[33]);

    fwh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_gated),
        .in_ready (ctrl_ready),
        .in_first (in_ch.data[32]),
        .in_last  (in_ch.data[33]),
        .op_count (opcnt_reg),
        .stat     (stat),
        .cmd      (cmd),
        .emit     (emit)
    );

    fwh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .word        (in_ch.data[31:0]),
        .init_a      (init_a_reg),
        .init_b      (init_b_reg),
        .init_c      (init_c_reg),
        .seed_select (seed_reg),
        .op_program  (prog_reg),
        .checksum    (checksum),
        .bad_op      (bad_op)
    );

    // output register; emit only arises after a last word was let in,
    // which needed the register empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {bad_op, checksum};
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_emit_empty, clk, rst_n, emit, !out_valid_reg || out_ch.ready)
endmodule

@@ tb/formula_word_hash_top_test.sv @@
// testbench for formula_word_hash_top: directed and random word streams,
// an in-bench hash predictor and a scoreboard on the result channel
// depends on fwh_pkg, fwh_stream_if and the formula_word_hash_top rtl
`timescale 1ns / 1ps

module formula_word_hash_top_test;
    import fwh_pkg::*;

    // variable numbers used inside an operation word
    localparam logic [1:0] VAR_A = 2'd0;
    localparam logic [1:0] VAR_B = 2'd1;
    localparam logic [1:0] VAR_C = 2'd2;
    localparam logic [1:0] VAR_D = 2'd3;
    // codes outside the known set, used to raise the error flag
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    // worst word: the load plus four divides, with some margin
    localparam int DrainCycles = 300;

    typedef struct packed {
        logic        status;
        logic [31:0] checksum;
    } sum_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrBits-1:0] paddr = '0;
    logic [63:0]         pwdata = '0;
    logic [63:0]         prdata;
    logic                pready;

    fwh_stream_if #(.W(34)) in_ch ();
    fwh_stream_if #(.W(33)) out_ch ();

    formula_word_hash_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // shadow copy of the configuration registers
    logic [63:0] cfg_init_a, cfg_init_b, cfg_init_c;
    logic [2:0]  cfg_seed_sel, cfg_op_count;
    logic [35:0] cfg_program;
    // shadow copy of the hash variables and the sticky error flag
    logic [63:0] hash_vars [4];
    logic        bad_code_seen;

    sum_beat_t pending_sums [$];
    int        mismatches = 0;
    int        words_sent = 0;
    int        sums_checked = 0;

    // receiver controls: a long hold-off set by a test, and a no-idle switch
    int hold_cycles = 0;
    bit no_idle = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_init_a = '0;
        cfg_init_b = '0;
        cfg_init_c = '0;
        cfg_seed_sel = '0;
        cfg_op_count = '0;
        cfg_program = '0;
        for (int i = 0; i < 4; i++)
            hash_vars[i] = '0;
        bad_code_seen = 1'b0;
    end

    // fixed seed table, kept apart from the package function
    function automatic logic [63:0] seed_value(input logic [2:0] sel);
        logic [31:0] seeds [8];
        seeds = '{32'hE7F4CB62, 32'hF6A14FFC, 32'hAA5504AF, 32'h871FCDC2,
                  32'h11BF6A18, 32'hC57292E6, 32'h7927D27E, 32'h2FEC8733};
        return {32'd0, seeds[sel]};
    endfunction

    function automatic logic [8:0] make_op(input logic [1:0] dst, input logic [1:0] s1,
                                           input logic [2:0] code, input logic [1:0] s2);
        return {s2, code, s1, dst};
    endfunction

    // predictor: one accepted word through the shadow hash
    task automatic hash_word(input logic [31:0] word, input logic first, input logic last);
        int          n;
        logic [8:0]  op;
        logic [63:0] x, y;
        sum_beat_t   sum;
        if (first) begin
            hash_vars[VAR_A] = cfg_init_a ^ seed_value(cfg_seed_sel);
            hash_vars[VAR_B] = cfg_init_b;
            hash_vars[VAR_C] = cfg_init_c;
            bad_code_seen = 1'b0;
        end
        hash_vars[VAR_D] = {32'd0, word};
        n = (cfg_op_count > MaxOps) ? MaxOps : cfg_op_count;
        for (int k = 0; k < n; k++) begin
            op = cfg_program[9*k +: 9];
            x = hash_vars[op[3:2]];
            y = hash_vars[op[8:7]];
            case (op[6:4])
                OP_ADD: hash_vars[op[1:0]] = x + y;
                OP_SUB: hash_vars[op[1:0]] = x - y;
                OP_XOR: hash_vars[op[1:0]] = x ^ y;
                OP_MUL: hash_vars[op[1:0]] = x * y;
                OP_DIV: hash_vars[op[1:0]] = (y == 0) ? '1 : x / y;
                default: bad_code_seen = 1'b1;
            endcase
        end
        if (last) begin
            sum.checksum = hash_vars[VAR_C][31:0];
            sum.status = bad_code_seen;
            pending_sums.push_back(sum);
        end
    endtask

    // apb write: setup cycle, then access cycle
    task automatic reg_write(input logic [AddrBits-1:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_INIT_A: cfg_init_a = value;
            ADDR_INIT_B: cfg_init_b = value;
            ADDR_INIT_C: cfg_init_c = value;
            ADDR_SEED:   cfg_seed_sel = value[2:0];
            ADDR_OPCNT:  cfg_op_count = value[2:0];
            ADDR_PROG:   cfg_program = value[35:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] a, input logic [63:0] b,
                               input logic [63:0] c, input logic [2:0] seed,
                               input logic [2:0] count, input logic [35:0] prog);
        reg_write(ADDR_INIT_A, a);
        reg_write(ADDR_INIT_B, b);
        reg_write(ADDR_INIT_C, c);
        reg_write(ADDR_SEED, {61'd0, seed});
        reg_write(ADDR_OPCNT, {61'd0, count});
        reg_write(ADDR_PROG, {28'd0, prog});
    endtask

    // block idle: all sums back, then room for a word still in flight
    task automatic wait_idle();
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // send one beat; valid stays high into the next beat when there is no gap
    task automatic send_word(input logic [31:0] word, input logic first, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.data <= {last, first, word};
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        hash_word(word, first, last);
        words_sent++;
    endtask

    task automatic end_stream();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, long hold-off on request, checks each beat
    initial begin : result_check
        int        stall;
        sum_beat_t got, want;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                sums_checked++;
                if (pending_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: checksum %h status %0d",
                                 got.checksum, got.status);
                end else begin
                    want = pending_sums.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: checksum exp %h got %h, status exp %0d got %0d",
                                     want.checksum, got.checksum, want.status, got.status);
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] pick_init();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [35:0] pick_program();
        logic [35:0] prog;
        logic [2:0]  code;
        for (int k = 0; k < MaxOps; k++) begin
            // mostly known codes, now and then an unknown one
            code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_BAD_LO, OP_BAD_HI))
                                               : 3'($urandom_range(OP_ADD, OP_DIV));
            prog[9*k +: 9] = make_op(2'($urandom), 2'($urandom), code, 2'($urandom));
        end
        return prog;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // extremes of every field, each operation, the special cases
    task automatic test_directed();
        logic [35:0] prog;
        // reset config: no operations, checksum is zero
        send_word(32'h0, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        end_stream();
        wait_idle();
        // add, sub, xor and mul once each into C, C = ((((C+D)-B)^A)*D)
        prog = {make_op(VAR_C, VAR_C, OP_MUL, VAR_D), make_op(VAR_C, VAR_C, OP_XOR, VAR_A),
                make_op(VAR_C, VAR_C, OP_SUB, VAR_B), make_op(VAR_C, VAR_C, OP_ADD, VAR_D)};
        load_config('1, 64'h0123_4567_89AB_CDEF, '1, 3'd7, 3'd4, prog);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b1);
        // no first: continues from the kept state
        send_word(32'h1234_5678, 1'b0, 1'b1);
        end_stream();
        wait_idle();
        // divide, by D and by zero, plus an unknown code in the middle
        prog = {make_op(VAR_A, VAR_A, OP_DIV, VAR_C), make_op(VAR_B, VAR_B, 3'd6, VAR_B),
                make_op(VAR_C, VAR_A, OP_DIV, VAR_B), make_op(VAR_C, VAR_C, OP_DIV, VAR_D)};
        load_config(64'd0, 64'd0, '1, 3'd0, 3'd4, prog);
        send_word(32'h0, 1'b1, 1'b1);
        send_word(32'h0000_0003, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        end_stream();
        wait_idle();
        // op count above the limit saturates, every seed gets a single-word run
        load_config('1, '1, 64'h5555_AAAA_5555_AAAA, 3'd0, 3'd7, '1);
        for (int s = 0; s < 8; s++) begin
            reg_write(ADDR_SEED, 64'(s));
            prog = {make_op(VAR_C, VAR_C, OP_XOR, VAR_A), make_op(VAR_C, VAR_C, OP_ADD, VAR_D),
                    make_op(VAR_C, VAR_C, OP_ADD, VAR_B), make_op(VAR_B, VAR_B, OP_SUB, VAR_D)};
            reg_write(ADDR_PROG, {28'd0, prog});
            reg_write(ADDR_OPCNT, 64'(5 + s % 3));
            send_word($urandom, 1'b1, 1'b1);
            end_stream();
            wait_idle();
        end
    endtask

    // random phases of well-formed runs, with noise and broken runs mixed in
    task automatic test_random(input int words);
        int sent, len;
        sent = 0;
        while (sent < words) begin
            no_idle = ($urandom_range(0, 4) == 0);
            load_config(pick_init(), pick_init(), pick_init(), 3'($urandom_range(0, 7)),
                        3'($urandom_range(0, 7)), pick_program());
            // in some phases a small op count keeps the words short
            if ($urandom_range(0, 2) == 0)
                reg_write(ADDR_OPCNT, 64'($urandom_range(0, 2)));
            for (int r = 0; r < 25 && sent < words; r++) begin
                len = $urandom_range(1, 6);
                if ($urandom_range(0, 7) == 0) begin
                    // broken run: random flags
                    for (int i = 0; i < len; i++)
                        send_word(pick_word(), 1'($urandom), 1'($urandom));
                end else begin
                    for (int i = 0; i < len; i++)
                        send_word(pick_word(), i == 0, i == len - 1);
                end
                sent += len;
            end
            end_stream();
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off long while many last words arrive, input must stall
    task automatic test_backpressure();
        load_config(pick_init(), pick_init(), pick_init(), 3'd3, 3'd1,
                    {27'd0, make_op(VAR_C, VAR_C, OP_ADD, VAR_D)});
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_word($urandom, i % 3 == 0, 1'b1);
        end_stream();
        wait_idle();
    endtask

    // sender pauses mid-stream until every sum is back
    task automatic test_drain_pause();
        load_config(pick_init(), pick_init(), pick_init(), 3'd5, 3'd4, pick_program());
        for (int i = 0; i < 12; i++)
            send_word($urandom, i == 0, i % 4 == 3);
        end_stream();
        while (pending_sums.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 12; i++)
            send_word($urandom, i == 6, i % 4 == 3);
        end_stream();
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1200);
        test_drain_pause();
        $display("sent %0d words, checked %0d checksums over directed, random,",
                 words_sent, sums_checked);
        $display("long hold-off and drained-pause phases; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
